>>> rtl/rrap_pkg.sv
// Package for the request array parser: field widths, character codes,
// parser phases, status codes and the result item type. No dependencies.
package rrap_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int ARGNUM_W  = 6;
  localparam int ALEN_W    = 32;
  localparam int TOTAL_W   = 7;
  localparam int FRAME_W   = 32;
  localparam int CFG_W     = 32;

  localparam int OUT_TDATA_W = 88;
  localparam int OUT_TUSER_W = 4;

  localparam int DEF_MAX_ARGUMENTS = 64;
  localparam int DEF_LENGTH_BITS   = 32;

  localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 32'd65536;

  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_STAR       = 4'd0,
    PH_COUNT      = 4'd1,
    PH_COUNT_LF   = 4'd2,
    PH_DOLLAR     = 4'd3,
    PH_LEN        = 4'd4,
    PH_LEN_LF     = 4'd5,
    PH_PAYLOAD    = 4'd6,
    PH_TRAIL1     = 4'd7,
    PH_TRAIL2_OK  = 4'd8,
    PH_TRAIL2_BAD = 4'd9
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2,
    ST_END   = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              end_marker;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic                payload_valid;
    logic [BYTE_W-1:0]   payload_byte;
    logic [ARGNUM_W-1:0] argument_number;
    logic                payload_last;
    logic                header_done;
    logic [ALEN_W-1:0]   announced_length;
    logic [TOTAL_W-1:0]  argument_total;
    logic [FRAME_W-1:0]  frame_length;
  } result_t;

endpackage

>>> rtl/rrap_in_stage.sv
// Input register of the request array parser: holds one accepted item.
// Depends on rrap_pkg.
module rrap_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rrap_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              held_valid,
  output rrap_pkg::in_item_t held_item
);
  import rrap_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign held_valid = valid_r;
  assign held_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

>>> rtl/rrap_parse.sv
// Parser state and per-byte step logic of the request array parser.
// Depends on rrap_pkg.
module rrap_parse #(
  parameter int MAX_ARGUMENTS = rrap_pkg::DEF_MAX_ARGUMENTS,
  parameter int LENGTH_BITS   = rrap_pkg::DEF_LENGTH_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  rrap_pkg::in_item_t         item,
  input  logic [rrap_pkg::CFG_W-1:0] frame_limit,
  output rrap_pkg::result_t          result
);
  import rrap_pkg::*;

  localparam int ARG_W = $clog2(MAX_ARGUMENTS + 1);
  localparam int NW    = LENGTH_BITS + 4;
  localparam int WX    = ((LENGTH_BITS > CFG_W) ? LENGTH_BITS : CFG_W) + 2;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic                   seen_r, seen_nxt;
  logic [ARG_W-1:0]       exp_r, exp_nxt;
  logic [ARG_W-1:0]       cur_r, cur_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [FRAME_W-1:0]     pos_r, pos_nxt;

  logic [FRAME_W-1:0] len;
  logic [NW-1:0]      acc10;
  logic               is_digit;
  logic [3:0]         digit;
  logic [WX-1:0]      acc_x;
  logic [WX-1:0]      max_x;
  logic [WX-1:0]      len_x;
  logic               len_bad;
  logic [ARG_W-1:0]   cur_inc;
  logic [15:0]        cur_ext;
  logic [15:0]        exp_ext;

  logic err, done, end_ok, hdr, pay, plast;

  assign len      = pos_r + 32'd1;
  assign is_digit = item.byte_value inside {[CH_ZERO:CH_NINE]};
  assign digit    = 4'(item.byte_value - CH_ZERO);
  assign acc10    = (NW'(acc_r) << 3) + (NW'(acc_r) << 1) + NW'(digit);
  assign acc_x    = WX'(acc_r);
  assign max_x    = WX'(frame_limit);
  assign len_x    = WX'(len);
  assign len_bad  = (acc_x > max_x) || ((len_x + acc_x) > max_x);
  assign cur_inc  = cur_r + 1'b1;
  assign cur_ext  = 16'(cur_r);
  assign exp_ext  = 16'(exp_r);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    exp_nxt   = exp_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    pos_nxt   = pos_r;
    err       = 1'b0;
    done      = 1'b0;
    end_ok    = 1'b0;
    hdr       = 1'b0;
    pay       = 1'b0;
    plast     = 1'b0;
    if (item.end_marker) begin
      end_ok = (phase_r == PH_STAR) && (pos_r == '0);
      err    = !end_ok;
    end else if (frame_limit == '0) begin
      err = 1'b1;
    end else begin
      case (phase_r)
        PH_STAR, PH_DOLLAR: begin
          if (item.byte_value != ((phase_r == PH_STAR) ? CH_STAR : CH_DOLLAR)) begin
            err = 1'b1;
          end else begin
            phase_nxt = (phase_r == PH_STAR) ? PH_COUNT : PH_LEN;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
          end
        end
        PH_COUNT, PH_LEN: begin
          if (item.byte_value == CH_CR) begin
            if (!seen_r) begin
              err = 1'b1;
            end else begin
              phase_nxt = (phase_r == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
            end
          end else if (!is_digit || (acc10[NW-1:LENGTH_BITS] != '0)) begin
            err = 1'b1;
          end else begin
            acc_nxt  = acc10[LENGTH_BITS-1:0];
            seen_nxt = 1'b1;
          end
        end
        PH_COUNT_LF: begin
          if (item.byte_value != CH_LF || acc_r == '0 ||
              acc_r > LENGTH_BITS'(MAX_ARGUMENTS)) begin
            err = 1'b1;
          end else begin
            exp_nxt   = acc_r[ARG_W-1:0];
            cur_nxt   = '0;
            phase_nxt = PH_DOLLAR;
          end
        end
        PH_LEN_LF: begin
          if (item.byte_value != CH_LF || len_bad) begin
            err = 1'b1;
          end else begin
            rem_nxt   = acc_r;
            hdr       = 1'b1;
            phase_nxt = (acc_r == '0) ? PH_TRAIL1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pay     = 1'b1;
          rem_nxt = rem_r - 1'b1;
          if (rem_r == LENGTH_BITS'(1)) begin
            plast     = 1'b1;
            phase_nxt = PH_TRAIL1;
          end
        end
        PH_TRAIL1: begin
          phase_nxt = (item.byte_value == CH_CR) ? PH_TRAIL2_OK : PH_TRAIL2_BAD;
        end
        PH_TRAIL2_OK, PH_TRAIL2_BAD: begin
          if (phase_r == PH_TRAIL2_BAD || item.byte_value != CH_LF) begin
            err = 1'b1;
          end else begin
            cur_nxt = cur_inc;
            if (cur_inc >= exp_r) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_DOLLAR;
            end
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (!err && !done && (len >= frame_limit)) begin
        err = 1'b1;
      end
    end
    if (err || done || item.end_marker) begin
      phase_nxt = PH_STAR;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      exp_nxt   = '0;
      cur_nxt   = '0;
      rem_nxt   = '0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = len;
    end
  end

  always_comb begin
    result = '0;
    if (end_ok) begin
      result.status = ST_END;
    end else if (err) begin
      result.status = ST_ERROR;
    end else begin
      result.status          = done ? ST_DONE : ST_BUSY;
      result.payload_valid   = pay;
      result.payload_byte    = pay ? item.byte_value : '0;
      result.argument_number = (pay || hdr) ? cur_ext[ARGNUM_W-1:0] : '0;
      result.payload_last    = plast;
      result.header_done     = hdr;
      result.announced_length = hdr ? acc_x[ALEN_W-1:0] : '0;
      result.argument_total  = done ? exp_ext[TOTAL_W-1:0] : '0;
      result.frame_length    = done ? len : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STAR;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      exp_r   <= '0;
      cur_r   <= '0;
      rem_r   <= '0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      exp_r   <= exp_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

>>> rtl/resp_request_array_parser_core.sv
// Request array parser top level: input register, parser step, result
// register and the frame size register. Depends on rrap_pkg, rrap_in_stage
// and rrap_parse.
// Items wait in the input register; results are held in the result register.
// Throughput: one item per cycle unless out_tready stalls; parser state closes the loop.
// Reset: rst_n clears the parser to await a new frame, empties both
// registers and sets the frame size limit to 65536.
module resp_request_array_parser_core #(
  parameter int MAX_ARGUMENTS = rrap_pkg::DEF_MAX_ARGUMENTS,
  parameter int LENGTH_BITS   = rrap_pkg::DEF_LENGTH_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // byte_value[7:0]
  input  logic [rrap_pkg::BYTE_W-1:0]      in_tdata,
  // end_marker
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // payload_byte[7:0], argument_number[13:8], announced_length[45:14],
  // argument_total[52:46], frame_length[84:53], zero[87:85]
  output logic [rrap_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status[1:0], payload_valid[2], header_done[3]
  output logic [rrap_pkg::OUT_TUSER_W-1:0] out_tuser,
  // payload_last
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rrap_pkg::CFG_W-1:0]       cfg_data
);
  import rrap_pkg::*;

  logic [CFG_W-1:0] max_frame_r;
  in_item_t         in_item;
  in_item_t         held_item;
  logic             held_valid;
  logic             advance;
  result_t          result;
  result_t          res_r;
  logic             out_valid_r, out_valid_nxt;

  assign in_item.byte_value = in_tdata;
  assign in_item.end_marker = in_tuser;
  assign advance   = held_valid && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  rrap_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  rrap_parse #(
    .MAX_ARGUMENTS (MAX_ARGUMENTS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (held_item),
    .frame_limit (max_frame_r),
    .result      (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      max_frame_r <= MAX_FRAME_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_frame_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.frame_length, res_r.argument_total,
                       res_r.announced_length, res_r.argument_number,
                       res_r.payload_byte};
  assign out_tuser  = {res_r.header_done, res_r.payload_valid, res_r.status};
  assign out_tlast  = res_r.payload_last;

endmodule

>>> dv/resp_request_array_parser_core_tb.sv
// Self-checking testbench for resp_request_array_parser_core: request frames,
// broken frames and noise are fed byte by byte and every result item is
// checked against a request parser model kept here. Depends on rrap_pkg.
module resp_request_array_parser_core_tb;
  import rrap_pkg::*;

  localparam int          CYCLE_LIMIT = 400000;
  localparam int          MAX_ARGS    = DEF_MAX_ARGUMENTS;
  localparam logic [63:0] NUM_MAX     = (64'd1 << DEF_LENGTH_BITS) - 64'd1;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [BYTE_W-1:0]      in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;

  resp_request_array_parser_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Parser model state.
  phase_t      prs_phase     = PH_STAR;
  logic [63:0] num_acc       = '0;
  logic        num_seen      = 1'b0;
  logic [63:0] args_expected = '0;
  logic [63:0] arg_index     = '0;
  logic [63:0] bytes_left    = '0;
  logic [63:0] frame_pos     = '0;
  logic [31:0] frame_cap     = MAX_FRAME_RESET;

  in_item_t    req_bytes[$];
  in_item_t    stream_q[$];
  result_t     awaited_results[$];

  int          gap_left      = 0;
  int          burst_left    = 0;
  logic [15:0] stall_mask    = 16'hFFFF;
  logic [15:0] stall_step    = '0;

  int          items_in        = 0;
  int          results_checked = 0;
  int          requests_done   = 0;
  int          parse_errors    = 0;
  int          clean_ends      = 0;
  int          payload_seen    = 0;
  int          settings_run    = 1;
  int          mismatches      = 0;
  int          cycle_count     = 0;

  logic [31:0] cap_plan[7] = '{32'd1, 32'd2, 32'd12, 32'd40, 32'hFFFF_FFFF, 32'd100,
                               32'd65536};

  function automatic void restart_request();
    prs_phase     = PH_STAR;
    num_acc       = '0;
    num_seen      = 1'b0;
    args_expected = '0;
    arg_index     = '0;
    bytes_left    = '0;
    frame_pos     = '0;
  endfunction

  function automatic bit accept_digit(logic [7:0] b);
    logic [63:0] d;
    if (b < CH_ZERO || b > CH_NINE) return 1'b1;
    d = 64'(b - CH_ZERO);
    if (num_acc > (NUM_MAX - d) / 64'd10) return 1'b1;
    num_acc  = num_acc * 64'd10 + d;
    num_seen = 1'b1;
    return 1'b0;
  endfunction

  function automatic result_t parse_byte(logic [7:0] b, logic mark);
    result_t     r;
    logic [63:0] cnt;
    logic        bad;
    logic        done;
    r    = '0;
    cnt  = frame_pos + 64'd1;
    bad  = 1'b0;
    done = 1'b0;
    if (mark) begin
      r.status = (prs_phase == PH_STAR && frame_pos == 0) ? ST_END : ST_ERROR;
      restart_request();
      return r;
    end
    if (frame_cap == 0) begin
      bad = 1'b1;
    end else begin
      case (prs_phase)
        PH_STAR: begin
          if (b != CH_STAR) bad = 1'b1;
          else begin
            prs_phase = PH_COUNT;
            num_acc   = '0;
            num_seen  = 1'b0;
          end
        end
        PH_COUNT, PH_LEN: begin
          if (b == CH_CR) begin
            if (!num_seen) bad = 1'b1;
            else prs_phase = (prs_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;
          end else begin
            bad = accept_digit(b);
          end
        end
        PH_COUNT_LF: begin
          if (b != CH_LF || num_acc == 0 || num_acc > 64'(MAX_ARGS)) bad = 1'b1;
          else begin
            args_expected = num_acc;
            arg_index     = '0;
            prs_phase     = PH_DOLLAR;
          end
        end
        PH_DOLLAR: begin
          if (b != CH_DOLLAR) bad = 1'b1;
          else begin
            prs_phase = PH_LEN;
            num_acc   = '0;
            num_seen  = 1'b0;
          end
        end
        PH_LEN_LF: begin
          if (b != CH_LF || num_acc > 64'(frame_cap) || cnt > 64'(frame_cap) - num_acc) begin
            bad = 1'b1;
          end else begin
            bytes_left         = num_acc;
            r.argument_number  = arg_index[ARGNUM_W-1:0];
            r.header_done      = 1'b1;
            r.announced_length = num_acc[ALEN_W-1:0];
            prs_phase          = (num_acc == 0) ? PH_TRAIL1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          r.payload_valid   = 1'b1;
          r.payload_byte    = b;
          r.argument_number = arg_index[ARGNUM_W-1:0];
          bytes_left        = bytes_left - 64'd1;
          if (bytes_left == 0) begin
            r.payload_last = 1'b1;
            prs_phase      = PH_TRAIL1;
          end
        end
        PH_TRAIL1: prs_phase = (b == CH_CR) ? PH_TRAIL2_OK : PH_TRAIL2_BAD;
        PH_TRAIL2_OK, PH_TRAIL2_BAD: begin
          if (prs_phase == PH_TRAIL2_BAD || b != CH_LF) bad = 1'b1;
          else begin
            arg_index = arg_index + 64'd1;
            if (arg_index >= args_expected) done = 1'b1;
            else prs_phase = PH_DOLLAR;
          end
        end
        default: bad = 1'b1;
      endcase
    end
    if (!bad && !done && cnt >= 64'(frame_cap)) bad = 1'b1;
    if (bad) begin
      r        = '0;
      r.status = ST_ERROR;
      restart_request();
    end else if (done) begin
      r.status         = ST_DONE;
      r.argument_total = args_expected[TOTAL_W-1:0];
      r.frame_length   = cnt[FRAME_W-1:0];
      restart_request();
    end else begin
      r.status  = ST_BUSY;
      frame_pos = cnt;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < 40) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string fname, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                results_checked, fname, got_v, want_v));
  endtask

  task automatic push_byte(logic [7:0] b);
    req_bytes.push_back('{b, 1'b0});
  endtask

  task automatic push_end();
    req_bytes.push_back('{8'($urandom()), 1'b1});
  endtask

  task automatic push_crlf();
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_number(logic [63:0] v);
    logic [7:0] digs[$];
    int         zeros;
    zeros = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    do begin
      digs.push_front(8'(64'(CH_ZERO) + v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    repeat (zeros) push_byte(CH_ZERO);
    foreach (digs[i]) push_byte(digs[i]);
  endtask

  // Moves the assembled bytes to the send queue, now and then damaging one
  // byte or cutting the frame short with an end marker.
  task automatic flush_request(bit mangle);
    int pick;
    int pos;
    pick = $urandom_range(0, 99);
    if (mangle && req_bytes.size() > 0 && pick < 10) begin
      pos = $urandom_range(0, req_bytes.size() - 1);
      case ($urandom_range(0, 5))
        0:       req_bytes[pos].byte_value = 8'($urandom());
        1:       req_bytes[pos].byte_value = CH_CR;
        2:       req_bytes[pos].byte_value = CH_LF;
        3:       req_bytes[pos].byte_value = 8'(CH_ZERO + $urandom_range(0, 9));
        4:       req_bytes[pos].byte_value = CH_STAR;
        default: req_bytes[pos].byte_value = CH_DOLLAR;
      endcase
    end else if (mangle && req_bytes.size() > 1 && pick < 14) begin
      pos = $urandom_range(1, req_bytes.size() - 1);
      while (req_bytes.size() > pos) void'(req_bytes.pop_back());
      push_end();
    end
    foreach (req_bytes[i]) stream_q.push_back(req_bytes[i]);
    req_bytes.delete();
  endtask

  task automatic push_request();
    int          pick;
    int          nargs;
    logic [63:0] cnt_val;
    logic [63:0] len_val;
    pick = $urandom_range(0, 99);
    if (pick < 4) cnt_val = 64'd0;
    else if (pick < 7) cnt_val = 64'(MAX_ARGS + $urandom_range(1, 3));
    else if (pick < 9) cnt_val = 64'd99_999_999_999;
    else if (pick < 14) cnt_val = 64'($urandom_range(1, MAX_ARGS));
    else cnt_val = 64'($urandom_range(1, 4));
    nargs = (cnt_val == 0 || cnt_val > 64'(MAX_ARGS)) ? $urandom_range(0, 1) : int'(cnt_val);
    push_byte(CH_STAR);
    push_number(cnt_val);
    push_crlf();
    for (int k = 0; k < nargs; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) len_val = NUM_MAX;
      else if (pick < 4) len_val = NUM_MAX + 64'($urandom_range(1, 9));
      else if (pick < 6) len_val = 64'($urandom());
      else if (pick < 16) len_val = 64'($urandom_range(0, 40));
      else len_val = 64'($urandom_range(0, 6));
      push_byte(CH_DOLLAR);
      push_number(len_val);
      push_crlf();
      if (len_val > 64) begin
        repeat ($urandom_range(0, 4)) push_byte(8'($urandom()));
        push_end();
        break;
      end
      repeat (int'(len_val)) push_byte(8'($urandom()));
      pick = $urandom_range(0, 59);
      if (pick == 0) push_byte(8'($urandom()));
      else push_byte(CH_CR);
      if (pick == 1) push_byte(8'($urandom()));
      else push_byte(CH_LF);
    end
    flush_request(1'b1);
  endtask

  task automatic fill_random(int quota);
    int base;
    int pick;
    base = stream_q.size();
    while (stream_q.size() - base < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom()));
        flush_request(1'b0);
      end else if (pick < 10) begin
        push_end();
        flush_request(1'b0);
      end else begin
        push_request();
      end
    end
  endtask

  task automatic wait_drained();
    while (stream_q.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_frame_cap(logic [31:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_cap = v;
    settings_run++;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_end();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_text("*1");
    push_crlf();
    push_text("$1");
    push_crlf();
    push_byte(8'hFF);
    push_crlf();
    push_text("*0");
    push_crlf();
    push_text("*");
    push_end();
    push_text("$");
    push_text("*65");
    push_crlf();
    flush_request(1'b0);

    fill_random(175);
    cap_plan[5] = 32'($urandom_range(60, 400));
    foreach (cap_plan[p]) begin
      wait_drained();
      repeat (4) @(posedge clk);
      write_frame_cap(cap_plan[p]);
      fill_random(175);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d items under %0d frame size settings; checked %0d results.",
             items_in, settings_run, results_checked);
    $display("Requests completed %0d, parse errors %0d, clean ends %0d, payload bytes %0d.",
             requests_done, parse_errors, clean_ends, payload_seen);
    if (mismatches == 0) begin
      $display("resp_request_array_parser_core_tb: done, clean");
    end else begin
      $display("resp_request_array_parser_core_tb: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin : drive_bytes
    in_item_t nxt;
    result_t  want;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = parse_byte(in_tdata, in_tuser);
        awaited_results.push_back(want);
        items_in++;
        case (want.status)
          ST_DONE:  requests_done++;
          ST_ERROR: parse_errors++;
          ST_END:   clean_ends++;
          default:  if (want.payload_valid) payload_seen++;
        endcase
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || stream_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          nxt = stream_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.byte_value;
          in_tuser  <= nxt.end_marker;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    stall_step = stall_step + 16'd1;
    if (stall_step[5:0] == 0)
      stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
    out_tready <= stall_mask[stall_step[3:0]];
    if (rst_n && out_tvalid && out_tready) begin
      got.payload_byte     = out_tdata[7:0];
      got.argument_number  = out_tdata[13:8];
      got.announced_length = out_tdata[45:14];
      got.argument_total   = out_tdata[52:46];
      got.frame_length     = out_tdata[84:53];
      got.status           = status_t'(out_tuser[1:0]);
      got.payload_valid    = out_tuser[2];
      got.header_done      = out_tuser[3];
      got.payload_last     = out_tlast;
      if (awaited_results.size() == 0) begin
        report_mismatch("result item arrived with nothing awaited");
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("payload_valid", 32'(got.payload_valid), 32'(want.payload_valid));
        check_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        check_field("argument_number", 32'(got.argument_number), 32'(want.argument_number));
        check_field("payload_last", 32'(got.payload_last), 32'(want.payload_last));
        check_field("header_done", 32'(got.header_done), 32'(want.header_done));
        check_field("announced_length", got.announced_length, want.announced_length);
        check_field("argument_total", 32'(got.argument_total), 32'(want.argument_total));
        check_field("frame_length", got.frame_length, want.frame_length);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d results still awaited.",
               awaited_results.size());
      $display("resp_request_array_parser_core_tb: done, errors");
      $finish;
    end
  end

endmodule
